// File: rtl/jpeg_marker_metadata_parser_unit_assert.svh
// Assertion macros used by the top level of the JPEG metadata parser.
`ifndef JPEG_MARKER_METADATA_PARSER_UNIT_ASSERT_SVH
`define JPEG_MARKER_METADATA_PARSER_UNIT_ASSERT_SVH

// Check that a condition implies a property in the same cycle.
`define JMMP_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Check that a condition implies a property in the next cycle.
`define JMMP_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: rtl/jmmp_pkg.sv
// Shared types, constants and signature tables of the JPEG metadata parser.
package jmmp_pkg;

    localparam int ICC_SLOTS = 256;
    localparam int IDX_W     = $clog2(ICC_SLOTS);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Configuration register indexes
    localparam logic CFG_ICC_LIMIT  = 1'b0;
    localparam logic CFG_META_LIMIT = 1'b1;

    // Result kinds and stream ids
    localparam logic       KIND_PAYLOAD = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;
    localparam logic [1:0] STREAM_ICC   = 2'd0;
    localparam logic [1:0] STREAM_EXIF  = 2'd1;
    localparam logic [1:0] STREAM_XMP   = 2'd2;

    // Status codes
    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_BAD_START    = 4'd1;
    localparam logic [3:0] ST_BAD_MARKER   = 4'd2;
    localparam logic [3:0] ST_TRUNC_MARKER = 4'd3;
    localparam logic [3:0] ST_TRUNC_LENGTH = 4'd4;
    localparam logic [3:0] ST_BAD_LENGTH   = 4'd5;
    localparam logic [3:0] ST_BAD_ICC_SEQ  = 4'd6;
    localparam logic [3:0] ST_ICC_OVER     = 4'd7;
    localparam logic [3:0] ST_EXIF_OVER    = 4'd8;
    localparam logic [3:0] ST_XMP_OVER     = 4'd9;
    localparam logic [3:0] ST_ICC_INCOMPL  = 4'd10;

    // Segment classes
    localparam logic [1:0] CL_NONE = 2'd0;
    localparam logic [1:0] CL_ICC  = 2'd1;
    localparam logic [1:0] CL_EXIF = 2'd2;
    localparam logic [1:0] CL_XMP  = 2'd3;

    // Signature candidate bits
    localparam int CAND_ICC  = 0;
    localparam int CAND_EXIF = 1;
    localparam int CAND_XMP  = 2;

    // Marker bytes
    localparam logic [7:0] MK_FILL = 8'hff;
    localparam logic [7:0] MK_SOI  = 8'hd8;
    localparam logic [7:0] MK_SOS  = 8'hda;
    localparam logic [7:0] MK_EOI  = 8'hd9;
    localparam logic [7:0] MK_TEM  = 8'h01;
    localparam logic [7:0] MK_RST0 = 8'hd0;
    localparam logic [7:0] MK_RST7 = 8'hd7;
    localparam logic [7:0] MK_APP2 = 8'he2;
    localparam logic [7:0] MK_APP1 = 8'he1;

    localparam int ICC_SIG_LEN  = 12;
    localparam int EXIF_SIG_LEN = 6;
    localparam int XMP_SIG_LEN  = 29;
    localparam int ICC_HDR_LEN  = 14;

    localparam logic [8*ICC_SIG_LEN-1:0]  ICC_SIG  = 96'h4943435f50524f46494c4500;
    localparam logic [8*EXIF_SIG_LEN-1:0] EXIF_SIG = 48'h457869660000;
    localparam logic [8*XMP_SIG_LEN-1:0]  XMP_SIG  =
        232'h687474703a2f2f6e732e61646f62652e636f6d2f7861702f312e302f00;

    typedef enum logic [7:0] {
        PH_START0 = 8'b0000_0001,
        PH_START1 = 8'b0000_0010,
        PH_MARK   = 8'b0000_0100,
        PH_FILL   = 8'b0000_1000,
        PH_LENHI  = 8'b0001_0000,
        PH_LENLO  = 8'b0010_0000,
        PH_DATA   = 8'b0100_0000,
        PH_DONE   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic       out_kind;
        logic [1:0] stream_id;
        logic [7:0] chunk_index;
        logic [7:0] chunk_total;
        logic [7:0] payload_byte;
        logic       segment_end;
        logic [3:0] status;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } push_t;

    function automatic logic [7:0] icc_sig_byte(input logic [4:0] idx);
        return ICC_SIG[8*(ICC_SIG_LEN-1-int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] exif_sig_byte(input logic [4:0] idx);
        return EXIF_SIG[8*(EXIF_SIG_LEN-1-int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] xmp_sig_byte(input logic [4:0] idx);
        return XMP_SIG[8*(XMP_SIG_LEN-1-int'(idx)) +: 8];
    endfunction

endpackage

// File: rtl/jmmp_core.sv
// Byte-wise marker walker, signature matcher and ICC sequence checker.
module jmmp_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  jmmp_pkg::in_item_t in_data,
    input  logic              cfg_fire,
    input  logic              cfg_index,
    input  logic [23:0]       cfg_data,
    output jmmp_pkg::push_t   push
);
    import jmmp_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [7:0]           marker_reg, marker_next;
    logic [15:0]          seg_len_reg, seg_len_next;
    logic [15:0]          seg_off_reg, seg_off_next;
    logic [2:0]           sig_reg, sig_next;
    logic [1:0]           class_reg, class_next;
    logic [7:0]           chunk_reg, chunk_next;
    logic [7:0]           icc_total_reg, icc_total_next;
    logic [ICC_SLOTS-1:0] seen_reg, seen_next;
    logic [7:0]           icc_count_reg, icc_count_next;
    logic [23:0]          icc_used_reg, icc_used_next;
    logic [1:0]           bytes_seen_reg, bytes_seen_next;
    logic [3:0]           err_reg, err_next;
    logic [3:0]           pend_reg, pend_next;
    logic [23:0]          icc_limit_reg;
    logic [15:0]          meta_limit_reg;

    always_comb
    begin
        logic [7:0]  b;
        logic [15:0] len;
        logic        last;
        logic [4:0]  oidx;
        logic [23:0] pl;
        logic [24:0] used_sum;
        logic [3:0]  st;
        logic        emit;
        out_item_t   pay;
        out_item_t   stat;

        b    = in_data.data_byte;
        len  = {seg_len_reg[15:8], b};
        last = ({1'b0, seg_off_reg} + 17'd1) == {1'b0, seg_len_reg};
        oidx = seg_off_reg[4:0];
        pl   = {8'd0, seg_len_reg} - 24'(ICC_HDR_LEN);
        used_sum = {1'b0, icc_used_reg} + {1'b0, pl};
        emit = 1'b0;
        st   = ST_OK;

        phase_next      = phase_reg;
        marker_next     = marker_reg;
        seg_len_next    = seg_len_reg;
        seg_off_next    = seg_off_reg;
        sig_next        = sig_reg;
        class_next      = class_reg;
        chunk_next      = chunk_reg;
        icc_total_next  = icc_total_reg;
        seen_next       = seen_reg;
        icc_count_next  = icc_count_reg;
        icc_used_next   = icc_used_reg;
        bytes_seen_next = bytes_seen_reg;
        err_next        = err_reg;
        pend_next       = pend_reg;

        pay  = '0;
        stat = '0;

        if (in_fire)
        begin
            if (bytes_seen_reg != 2'd3)
            begin
                bytes_seen_next = bytes_seen_reg + 2'd1;
            end

            // Advance the parse unless an error already holds
            if (err_reg == ST_OK)
            begin
                case (phase_reg)
                    PH_START0:
                    begin
                        if (b != MK_FILL) err_next = ST_BAD_START;
                        else phase_next = PH_START1;
                    end
                    PH_START1:
                    begin
                        if (b != MK_SOI) err_next = ST_BAD_START;
                        else phase_next = PH_MARK;
                    end
                    PH_MARK:
                    begin
                        if (b != MK_FILL) err_next = ST_BAD_MARKER;
                        else phase_next = PH_FILL;
                    end
                    PH_FILL:
                    begin
                        if (b == MK_FILL)
                        begin
                            phase_next = PH_FILL;
                        end
                        else if (b == MK_SOS || b == MK_EOI)
                        begin
                            phase_next = PH_DONE;
                        end
                        else if (b == MK_TEM || (b >= MK_RST0 && b <= MK_RST7))
                        begin
                            phase_next = PH_MARK;
                        end
                        else
                        begin
                            marker_next = b;
                            phase_next  = PH_LENHI;
                        end
                    end
                    PH_LENHI:
                    begin
                        seg_len_next = {b, 8'h00};
                        phase_next   = PH_LENLO;
                    end
                    PH_LENLO:
                    begin
                        if (len < 16'd2)
                        begin
                            err_next = ST_BAD_LENGTH;
                        end
                        else
                        begin
                            seg_len_next = len - 16'd2;
                            seg_off_next = '0;
                            class_next   = CL_NONE;
                            pend_next    = ST_OK;
                            chunk_next   = '0;
                            sig_next     = '0;
                            if (marker_reg == MK_APP2 && seg_len_next >= 16'(ICC_HDR_LEN))
                                sig_next[CAND_ICC] = 1'b1;
                            if (meta_limit_reg != '0 && marker_reg == MK_APP1)
                            begin
                                if (seg_len_next >= 16'(EXIF_SIG_LEN))
                                    sig_next[CAND_EXIF] = 1'b1;
                                if (seg_len_next >= 16'(XMP_SIG_LEN))
                                    sig_next[CAND_XMP] = 1'b1;
                            end
                            phase_next = (seg_len_next == '0) ? PH_MARK : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        // Match signatures while the segment is unclassified
                        if (class_reg == CL_NONE && pend_reg == ST_OK)
                        begin
                            if (sig_reg[CAND_ICC] && seg_off_reg < 16'(ICC_SIG_LEN))
                            begin
                                if (b != icc_sig_byte(oidx))
                                    sig_next[CAND_ICC] = 1'b0;
                                else if (seg_off_reg == 16'(ICC_SIG_LEN - 1))
                                    class_next = CL_ICC;
                            end
                            if (sig_reg[CAND_EXIF] && seg_off_reg < 16'(EXIF_SIG_LEN))
                            begin
                                if (b != exif_sig_byte(oidx))
                                    sig_next[CAND_EXIF] = 1'b0;
                                else if (seg_off_reg == 16'(EXIF_SIG_LEN - 1))
                                begin
                                    if (seg_len_reg - 16'(EXIF_SIG_LEN) > meta_limit_reg)
                                        pend_next = ST_EXIF_OVER;
                                    else
                                        class_next = CL_EXIF;
                                end
                            end
                            if (sig_reg[CAND_XMP] && seg_off_reg < 16'(XMP_SIG_LEN))
                            begin
                                if (b != xmp_sig_byte(oidx))
                                    sig_next[CAND_XMP] = 1'b0;
                                else if (seg_off_reg == 16'(XMP_SIG_LEN - 1))
                                begin
                                    if (seg_len_reg - 16'(XMP_SIG_LEN) > meta_limit_reg)
                                        pend_next = ST_XMP_OVER;
                                    else
                                        class_next = CL_XMP;
                                end
                            end
                        end
                        else if (class_reg == CL_ICC)
                        begin
                            if (seg_off_reg == 16'(ICC_SIG_LEN))
                            begin
                                chunk_next = b;
                            end
                            else if (seg_off_reg == 16'(ICC_SIG_LEN + 1))
                            begin
                                // Check the chunk header against the sequence so far
                                if (chunk_reg == '0 || b == '0 || chunk_reg > b ||
                                    {1'b0, chunk_reg} >= 9'(ICC_SLOTS) ||
                                    seen_reg[chunk_reg[IDX_W-1:0]] ||
                                    (icc_total_reg != '0 && icc_total_reg != b))
                                begin
                                    pend_next = ST_BAD_ICC_SEQ;
                                end
                                else if (used_sum > {1'b0, icc_limit_reg})
                                begin
                                    pend_next = ST_ICC_OVER;
                                end
                                else
                                begin
                                    icc_total_next = b;
                                    seen_next[chunk_reg[IDX_W-1:0]] = 1'b1;
                                    icc_count_next = icc_count_reg + 8'd1;
                                    icc_used_next  = used_sum[23:0];
                                end
                                if (pend_next != ST_OK) class_next = CL_NONE;
                            end
                            else if (seg_off_reg >= 16'(ICC_HDR_LEN) && pend_reg == ST_OK)
                            begin
                                emit = 1'b1;
                                pay.stream_id   = STREAM_ICC;
                                pay.chunk_index = chunk_reg;
                                pay.chunk_total = icc_total_reg;
                            end
                        end
                        else if (class_reg == CL_EXIF && pend_reg == ST_OK)
                        begin
                            emit = 1'b1;
                            pay.stream_id = STREAM_EXIF;
                        end
                        else if (class_reg == CL_XMP && pend_reg == ST_OK)
                        begin
                            emit = 1'b1;
                            pay.stream_id = STREAM_XMP;
                        end

                        pay.out_kind     = KIND_PAYLOAD;
                        pay.payload_byte = b;
                        pay.segment_end  = last;

                        seg_off_next = seg_off_reg + 16'd1;
                        if (last)
                        begin
                            if (pend_next != ST_OK) err_next = pend_next;
                            phase_next = PH_MARK;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end

            // Report the buffer status and restart on its last byte
            if (in_data.end_of_buffer)
            begin
                if (bytes_seen_reg != 2'd3)          st = ST_BAD_START;
                else if (err_next != ST_OK)          st = err_next;
                else if (phase_next == PH_FILL)      st = ST_TRUNC_MARKER;
                else if (phase_next == PH_LENHI || phase_next == PH_LENLO)
                                                     st = ST_TRUNC_LENGTH;
                else if (phase_next == PH_DATA)      st = ST_BAD_LENGTH;
                else                                 st = ST_OK;
                if (st == ST_OK && icc_count_next != icc_total_next) st = ST_ICC_INCOMPL;
                stat.out_kind = KIND_STATUS;
                stat.status   = st;

                phase_next      = PH_START0;
                marker_next     = '0;
                seg_len_next    = '0;
                seg_off_next    = '0;
                sig_next        = 3'b111;
                class_next      = CL_NONE;
                chunk_next      = '0;
                icc_total_next  = '0;
                seen_next       = '0;
                icc_count_next  = '0;
                icc_used_next   = '0;
                bytes_seen_next = '0;
                err_next        = ST_OK;
                pend_next       = ST_OK;
            end
        end

        // Order the requests: payload byte before status
        push = '0;
        if (emit)
        begin
            push.first = pay;
            push.second = stat;
            push.count = (in_fire && in_data.end_of_buffer) ? 2'd2 : 2'd1;
        end
        else if (in_fire && in_data.end_of_buffer)
        begin
            push.first = stat;
            push.count = 2'd1;
        end
    end

    // Hold parse state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_START0;
            marker_reg     <= '0;
            seg_len_reg    <= '0;
            seg_off_reg    <= '0;
            sig_reg        <= 3'b111;
            class_reg      <= CL_NONE;
            chunk_reg      <= '0;
            icc_total_reg  <= '0;
            seen_reg       <= '0;
            icc_count_reg  <= '0;
            icc_used_reg   <= '0;
            bytes_seen_reg <= '0;
            err_reg        <= ST_OK;
            pend_reg       <= ST_OK;
            icc_limit_reg  <= 24'hff_ffff;
            meta_limit_reg <= 16'hffff;
        end
        else
        begin
            phase_reg      <= phase_next;
            marker_reg     <= marker_next;
            seg_len_reg    <= seg_len_next;
            seg_off_reg    <= seg_off_next;
            sig_reg        <= sig_next;
            class_reg      <= class_next;
            chunk_reg      <= chunk_next;
            icc_total_reg  <= icc_total_next;
            seen_reg       <= seen_next;
            icc_count_reg  <= icc_count_next;
            icc_used_reg   <= icc_used_next;
            bytes_seen_reg <= bytes_seen_next;
            err_reg        <= err_next;
            pend_reg       <= pend_next;
            if (cfg_fire && cfg_index == CFG_ICC_LIMIT)
                icc_limit_reg <= cfg_data;
            if (cfg_fire && cfg_index == CFG_META_LIMIT)
                meta_limit_reg <= cfg_data[15:0];
        end
    end

endmodule

// File: rtl/jmmp_ofifo.sv
// Small result queue that takes up to two requests per cycle and returns one per cycle while out_stall is low.
module jmmp_ofifo (
    input  logic                clk,
    input  logic                rst_n,
    input  jmmp_pkg::push_t     push,
    input  logic                out_stall,
    output logic                out_valid,
    output jmmp_pkg::out_item_t out_data,
    output logic                full,
    output logic [jmmp_pkg::FIFO_CNT_W-1:0] level
);
    import jmmp_pkg::*;

    out_item_t               entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    // Keep room for two requests from the next byte
    assign full      = (count_reg > FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign level     = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        count_next  = count_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
    end

    // Store requests
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entry_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.second;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/jpeg_marker_metadata_parser_unit.sv
// Top level of the JPEG marker-segment metadata parser.
// Usage:
//  - Input channel in_valid/in_stall/in_data carries one buffer byte per request,
//    with end_of_buffer set on the last byte of a buffer.
//  - Output channel out_valid/out_stall/out_data returns payload bytes of ICC,
//    Exif and XMP segments, and one status request after each buffer's last byte.
//  - Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the ICC
//    byte limit (index 0) and the Exif/XMP byte limit (index 1); cfg_ready is
//    always high. Write only while the block is idle.
//  - An accepted byte's results are registered in the result queue.
//  - Throughput: one byte per cycle while in_stall is low; the parse state advances
//    in one registered step. A payload byte that ends a buffer makes two results,
//    which leave one per cycle while out_stall is low, through a four-entry result queue.
//  - in_stall rises when the result queue holds more than two requests, so a
//    stalled receiver backs up to the input.
//  - Reset clears the parse state, empties the queue and sets both limits to
//    their maximum. Parse state also clears after each buffer's status.
module jpeg_marker_metadata_parser_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  jmmp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output jmmp_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [23:0]         cfg_data
);
    import jmmp_pkg::*;

    push_t                 push;
    logic                  full;
    logic                  in_fire;
    logic [FIFO_CNT_W-1:0] level;

    assign in_stall  = full;
    assign in_fire   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    jmmp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_data   (in_data),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    jmmp_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .full      (full),
        .level     (level)
    );

`include "jpeg_marker_metadata_parser_unit_assert.svh"

    `JMMP_ASSERT_NOW(a_level_bound, 1'b1, level <= FIFO_CNT_W'(FIFO_DEPTH), "queue overflow")
    `JMMP_ASSERT_NOW(a_eob_status, in_fire && in_data.end_of_buffer, push.count != 2'd0, "no status")
    `JMMP_ASSERT_NOW(a_push_gated, !in_fire, push.count == 2'd0, "request without input")
    `JMMP_ASSERT_NEXT(a_eob_queued, in_fire && in_data.end_of_buffer, out_valid, "status lost")

endmodule

// File: test/testbench.sv
// Self-checking testbench for the JPEG marker-segment metadata parser.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import jmmp_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 8;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [23:0] cfg_data;

    jpeg_marker_metadata_parser_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Parser state mirrored by the predictor
    typedef enum int {
        P_START0, P_START1, P_MARK, P_FILL, P_LENHI, P_LENLO, P_DATA, P_DONE
    } pphase_t;

    logic [23:0] lim_icc;
    logic [15:0] lim_meta;
    pphase_t     p_phase;
    logic [7:0]  p_marker;
    int unsigned p_seg_len;
    int unsigned p_seg_off;
    logic [2:0]  p_cand;
    logic [1:0]  p_class;
    logic [7:0]  p_chunk;
    logic [7:0]  p_total;
    logic        p_seen [ICC_SLOTS];
    logic [7:0]  p_count;
    logic [23:0] p_used;
    int unsigned p_nbytes;
    logic [3:0]  p_err;
    logic [3:0]  p_pend;

    out_item_t   expected_results[$];
    int          error_count;
    int          idle_cycles;
    bit          stim_done;
    bit          hold_receiver;
    bit          quiet_mode;

    // Directed table rows; a row with chk set also carries the expected status
    typedef struct {
        logic [7:0] b;
        logic       eob;
        logic       chk;
        logic [3:0] st;
    } row_t;

    // Signature byte k of the ICC, Exif or XMP header
    function automatic logic [7:0] sig_char(input int which, input int unsigned k);
        logic [4:0] idx;
        idx = 5'(k);
        if (which == 0) return icc_sig_byte(idx);
        else if (which == 1) return exif_sig_byte(idx);
        else return xmp_sig_byte(idx);
    endfunction

    function automatic void clear_parse();
        p_phase = P_START0;
        p_marker = '0;
        p_seg_len = 0;
        p_seg_off = 0;
        p_cand = 3'b111;
        p_class = CL_NONE;
        p_chunk = '0;
        p_total = '0;
        foreach (p_seen[i]) p_seen[i] = 1'b0;
        p_count = '0;
        p_used = '0;
        p_nbytes = 0;
        p_err = ST_OK;
        p_pend = ST_OK;
    endfunction

    function automatic out_item_t payload_item(input logic [1:0] sid, input logic [7:0] idx,
                                               input logic [7:0] tot, input logic [7:0] b,
                                               input logic last);
        out_item_t r;
        r = '0;
        r.out_kind = KIND_PAYLOAD;
        r.stream_id = sid;
        r.chunk_index = idx;
        r.chunk_total = tot;
        r.payload_byte = b;
        r.segment_end = last;
        return r;
    endfunction

    // Work out the results of one accepted byte and queue them
    function automatic void predict_byte(input logic [7:0] b, input logic eob);
        int unsigned prior;
        int unsigned len;
        int unsigned off;
        logic last;
        int unsigned pl;
        out_item_t r;
        logic [3:0] st;
        prior = p_nbytes;
        if (p_nbytes < 3) p_nbytes++;
        if (p_err == ST_OK) begin
            case (p_phase)
                P_START0: if (b != MK_FILL) p_err = ST_BAD_START; else p_phase = P_START1;
                P_START1: if (b != MK_SOI) p_err = ST_BAD_START; else p_phase = P_MARK;
                P_MARK: if (b != MK_FILL) p_err = ST_BAD_MARKER; else p_phase = P_FILL;
                P_FILL:
                begin
                    if (b == MK_SOS || b == MK_EOI) p_phase = P_DONE;
                    else if (b == MK_TEM || (b >= MK_RST0 && b <= MK_RST7)) p_phase = P_MARK;
                    else if (b != MK_FILL)
                    begin
                        p_marker = b;
                        p_phase = P_LENHI;
                    end
                end
                P_LENHI:
                begin
                    p_seg_len = int'(b) << 8;
                    p_phase = P_LENLO;
                end
                P_LENLO:
                begin
                    len = p_seg_len | int'(b);
                    if (len < 2) p_err = ST_BAD_LENGTH;
                    else
                    begin
                        p_seg_len = len - 2;
                        p_seg_off = 0;
                        p_class = CL_NONE;
                        p_pend = ST_OK;
                        p_chunk = '0;
                        p_cand = '0;
                        if (p_marker == MK_APP2 && p_seg_len >= ICC_HDR_LEN)
                            p_cand[CAND_ICC] = 1'b1;
                        if (lim_meta != 0 && p_marker == MK_APP1)
                        begin
                            if (p_seg_len >= EXIF_SIG_LEN) p_cand[CAND_EXIF] = 1'b1;
                            if (p_seg_len >= XMP_SIG_LEN) p_cand[CAND_XMP] = 1'b1;
                        end
                        p_phase = (p_seg_len == 0) ? P_MARK : P_DATA;
                    end
                end
                P_DATA:
                begin
                    off = p_seg_off;
                    last = (off + 1 == p_seg_len);
                    if (p_class == CL_NONE && p_pend == ST_OK)
                    begin
                        if (p_cand[CAND_ICC] && off < ICC_SIG_LEN)
                        begin
                            if (b != sig_char(0, off)) p_cand[CAND_ICC] = 1'b0;
                            else if (off == ICC_SIG_LEN - 1) p_class = CL_ICC;
                        end
                        if (p_cand[CAND_EXIF] && off < EXIF_SIG_LEN)
                        begin
                            if (b != sig_char(1, off)) p_cand[CAND_EXIF] = 1'b0;
                            else if (off == EXIF_SIG_LEN - 1)
                            begin
                                if (p_seg_len - EXIF_SIG_LEN > lim_meta) p_pend = ST_EXIF_OVER;
                                else p_class = CL_EXIF;
                            end
                        end
                        if (p_cand[CAND_XMP] && off < XMP_SIG_LEN)
                        begin
                            if (b != sig_char(2, off)) p_cand[CAND_XMP] = 1'b0;
                            else if (off == XMP_SIG_LEN - 1)
                            begin
                                if (p_seg_len - XMP_SIG_LEN > lim_meta) p_pend = ST_XMP_OVER;
                                else p_class = CL_XMP;
                            end
                        end
                    end
                    else if (p_class == CL_ICC)
                    begin
                        if (off == 12) p_chunk = b;
                        else if (off == 13)
                        begin
                            pl = p_seg_len - 14;
                            if (p_chunk == 0 || b == 0 || p_chunk > b || p_seen[p_chunk] ||
                                (p_total != 0 && p_total != b))
                                p_pend = ST_BAD_ICC_SEQ;
                            else if (longint'(p_used) + pl > longint'(lim_icc))
                                p_pend = ST_ICC_OVER;
                            else
                            begin
                                p_total = b;
                                p_seen[p_chunk] = 1'b1;
                                p_count = p_count + 8'd1;
                                p_used = p_used + 24'(pl);
                            end
                            if (p_pend != ST_OK) p_class = CL_NONE;
                        end
                        else if (off >= 14 && p_pend == ST_OK)
                            expected_results.push_back(
                                payload_item(STREAM_ICC, p_chunk, p_total, b, last));
                    end
                    else if (p_class == CL_EXIF && p_pend == ST_OK)
                        expected_results.push_back(
                            payload_item(STREAM_EXIF, 8'd0, 8'd0, b, last));
                    else if (p_class == CL_XMP && p_pend == ST_OK)
                        expected_results.push_back(
                            payload_item(STREAM_XMP, 8'd0, 8'd0, b, last));
                    p_seg_off = (off + 1) & 16'hffff;
                    if (last)
                    begin
                        if (p_pend != ST_OK) p_err = p_pend;
                        p_phase = P_MARK;
                    end
                end
                default: ;
            endcase
        end
        if (eob) begin
            if (prior < 3) st = ST_BAD_START;
            else if (p_err != ST_OK) st = p_err;
            else if (p_phase == P_FILL) st = ST_TRUNC_MARKER;
            else if (p_phase == P_LENHI || p_phase == P_LENLO) st = ST_TRUNC_LENGTH;
            else if (p_phase == P_DATA) st = ST_BAD_LENGTH;
            else st = ST_OK;
            if (st == ST_OK && p_count != p_total) st = ST_ICC_INCOMPL;
            r = '0;
            r.out_kind = KIND_STATUS;
            r.status = st;
            expected_results.push_back(r);
            clear_parse();
        end
    endfunction

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Send one request, holding it until accepted
    task automatic send_byte(input logic [7:0] b, input logic eob);
        while (!quiet_mode && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.data_byte <= b;
        in_data.end_of_buffer <= eob;
        do @(posedge clk); while (in_stall);
        predict_byte(b, eob);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_ICC_LIMIT) lim_icc = val;
        else lim_meta = val[15:0];
    endtask

    // Queue of bytes making one buffer
    logic [7:0] buf_bytes[$];

    function automatic void add_segment(input logic [7:0] mk, input int kind,
                                        input int plen, input logic [7:0] idx,
                                        input logic [7:0] tot);
        int unsigned len;
        int hdr;
        len = plen + 2;
        buf_bytes.push_back(MK_FILL);
        if ($urandom_range(9) == 0) buf_bytes.push_back(MK_FILL);
        buf_bytes.push_back(mk);
        buf_bytes.push_back(len[15:8]);
        buf_bytes.push_back(len[7:0]);
        hdr = (kind == 0) ? ICC_SIG_LEN : (kind == 1) ? EXIF_SIG_LEN :
              (kind == 2) ? XMP_SIG_LEN : 0;
        for (int k = 0; k < plen; k++) begin
            if (k < hdr) buf_bytes.push_back(sig_char(kind, k));
            else if (kind == 0 && k == 12) buf_bytes.push_back(idx);
            else if (kind == 0 && k == 13) buf_bytes.push_back(tot);
            else buf_bytes.push_back(8'($urandom));
        end
        // Occasionally corrupt one byte of the signature
        if (hdr > 0 && $urandom_range(14) == 0)
            buf_bytes[buf_bytes.size() - plen + $urandom_range(hdr - 1)] = 8'($urandom);
    endfunction

    function automatic void build_buffer();
        int nseg;
        int kind;
        int tot;
        int len;
        buf_bytes.delete();
        if ($urandom_range(19) == 0) begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++) buf_bytes.push_back(8'($urandom));
            return;
        end
        buf_bytes.push_back(MK_FILL);
        buf_bytes.push_back(MK_SOI);
        nseg = $urandom_range(1, 4);
        tot = $urandom_range(1, 3);
        for (int s = 0; s < nseg; s++) begin
            kind = $urandom_range(0, 4);
            case (kind)
                0: add_segment(MK_APP2, 0, 14 + $urandom_range(0, 8),
                               8'($urandom_range(0, 5) == 0 ? $urandom : s + 1),
                               8'($urandom_range(0, 7) == 0 ? $urandom : tot));
                1: add_segment(MK_APP1, 1, 6 + $urandom_range(0, 8), 0, 0);
                2: add_segment(MK_APP1, 2, 29 + $urandom_range(0, 6), 0, 0);
                3:
                begin
                    buf_bytes.push_back(MK_FILL);
                    buf_bytes.push_back($urandom_range(1) ? MK_TEM :
                                        8'(MK_RST0 + $urandom_range(7)));
                end
                default: add_segment(8'($urandom_range(8'hc0, 8'hfe)), 3,
                                     $urandom_range(0, 6), 0, 0);
            endcase
        end
        if ($urandom_range(3) != 0) begin
            buf_bytes.push_back(MK_FILL);
            buf_bytes.push_back($urandom_range(1) ? MK_EOI : MK_SOS);
            repeat ($urandom_range(0, 2)) buf_bytes.push_back(8'($urandom));
        end
        // Noise: truncate or flip a byte
        if ($urandom_range(7) == 0 && buf_bytes.size() > 4)
            buf_bytes = buf_bytes[0:$urandom_range(3, buf_bytes.size() - 1)];
        if ($urandom_range(9) == 0)
            buf_bytes[$urandom_range(buf_bytes.size() - 1)] = 8'($urandom);
    endfunction

    row_t dir_rows[$];

    function automatic void add_row(input logic [7:0] b, input logic eob,
                                    input logic chk = 1'b0, input logic [3:0] st = ST_OK);
        row_t r;
        r.b = b;
        r.eob = eob;
        r.chk = chk;
        r.st = st;
        dir_rows.push_back(r);
    endfunction

    // Stimulus
    initial begin
        int sent;
        int bi;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ICC_LIMIT;
        cfg_data = '0;
        stim_done = 1'b0;
        quiet_mode = 1'b0;
        error_count = 0;
        lim_icc = 24'hffffff;
        lim_meta = 16'hffff;
        clear_parse();
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: short buffer, bad start, trailing bytes, bad length, bad marker, fill, restart
        add_row(MK_FILL, 1'b1, 1'b1, ST_BAD_START);
        add_row(8'h00, 1'b0); add_row(8'hd8, 1'b0); add_row(8'hff, 1'b0);
        add_row(8'hff, 1'b1, 1'b1, ST_BAD_START);
        add_row(MK_FILL, 1'b0); add_row(MK_SOI, 1'b0); add_row(MK_FILL, 1'b0);
        add_row(MK_FILL, 1'b0); add_row(MK_TEM, 1'b0); add_row(MK_FILL, 1'b0);
        add_row(MK_RST7, 1'b0); add_row(MK_FILL, 1'b0); add_row(8'hc0, 1'b0);
        add_row(8'h00, 1'b0); add_row(8'h01, 1'b1, 1'b1, ST_BAD_LENGTH);
        add_row(MK_FILL, 1'b0); add_row(MK_SOI, 1'b0); add_row(8'h00, 1'b0);
        add_row(8'hff, 1'b1, 1'b1, ST_BAD_MARKER);
        add_row(MK_FILL, 1'b0); add_row(MK_SOI, 1'b0); add_row(MK_FILL, 1'b0);
        add_row(MK_EOI, 1'b0); add_row(8'h00, 1'b1, 1'b1, ST_OK);
        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].b, dir_rows[i].eob);
            if (dir_rows[i].chk && (expected_results.size() == 0 ||
                expected_results[$].status != dir_rows[i].st)) begin
                $display("%0t directed row %0d: expected status %0d, actual %0d",
                         $time, i, dir_rows[i].st,
                         expected_results.size() ? expected_results[$].status : 4'd0);
                error_count++;
            end
        end
        drain();

        // Random buffers across several limit settings
        sent = 0;
        bi = 0;
        while (sent < 850) begin
            if (bi % 8 == 0) begin
                drain();
                case ((bi / 8) % 5)
                    0: begin write_reg(CFG_ICC_LIMIT, 24'hffffff);
                             write_reg(CFG_META_LIMIT, 24'h00ffff); end
                    1: begin write_reg(CFG_ICC_LIMIT, 24'd0);
                             write_reg(CFG_META_LIMIT, 24'd0); end
                    2: begin write_reg(CFG_ICC_LIMIT, 24'($urandom_range(0, 12)));
                             write_reg(CFG_META_LIMIT, 24'($urandom_range(1, 10))); end
                    3: begin write_reg(CFG_ICC_LIMIT, 24'($urandom));
                             write_reg(CFG_META_LIMIT, 24'($urandom) & 24'h00ffff); end
                    default: begin write_reg(CFG_ICC_LIMIT, 24'd8);
                             write_reg(CFG_META_LIMIT, 24'd3); end
                endcase
            end
            quiet_mode = (bi >= 40 && bi < 55);
            build_buffer();
            foreach (buf_bytes[k]) begin
                send_byte(buf_bytes[k], k == buf_bytes.size() - 1);
                sent++;
            end
            bi++;
        end
        drain();
        stim_done = 1'b1;
        if (error_count == 0 && expected_results.size() == 0)
            $display("[jpeg_marker_metadata_parser_unit] OK");
        else
            $display("[jpeg_marker_metadata_parser_unit] ERROR");
        $finish;
    end

    // Receiver stall: random, quiet window, and one long hold-off
    initial begin
        out_stall = 1'b0;
        hold_receiver = 1'b0;
        @(posedge rst_n);
        repeat (300) @(posedge clk);
        out_stall <= 1'b1;
        hold_receiver = 1'b1;
        repeat (60) @(posedge clk);
        hold_receiver = 1'b0;
        forever begin
            out_stall <= (!quiet_mode && $urandom_range(99) < 17);
            @(posedge clk);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        out_item_t exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, out_data);
                error_count++;
            end
            else begin
                exp_r = expected_results.pop_front();
                if (out_data.out_kind !== exp_r.out_kind ||
                    out_data.stream_id !== exp_r.stream_id ||
                    out_data.chunk_index !== exp_r.chunk_index ||
                    out_data.chunk_total !== exp_r.chunk_total ||
                    out_data.payload_byte !== exp_r.payload_byte ||
                    out_data.segment_end !== exp_r.segment_end ||
                    out_data.status !== exp_r.status) begin
                    $display("%0t mismatch: expected %h, actual %h", $time, exp_r, out_data);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no accepted request
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT) begin
            $display("[jpeg_marker_metadata_parser_unit] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
